// File: hdl/lfss_pkg.sv
// shared constants and types for the largest free square scan
package lfss_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int SIZE_W  = 11;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;
  localparam int COL_AW  = $clog2(MAX_COLUMNS);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(1);

  typedef logic [SIZE_W-1:0] size_t;

  // one cycle of row store traffic
  typedef struct packed {
    logic              we;
    logic [COL_AW-1:0] wr_addr;
    size_t             wr_data;
    logic [COL_AW-1:0] rd_addr;
  } ram_req_t;

endpackage

// File: hdl/lfss_row_ram.sv
// previous-row size store: one write port, one registered read port, write-first
module lfss_row_ram (
  input  logic             clk,
  input  lfss_pkg::ram_req_t req,
  output lfss_pkg::size_t  rd_data
);

  lfss_pkg::size_t mem [lfss_pkg::MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read of the entry written in the same cycle returns the new value
  always_ff @(posedge clk) begin
    if (req.we && (req.wr_addr == req.rd_addr)) begin
      rd_data <= req.wr_data;
    end else begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: hdl/largest_free_square_scan_top.sv
// largest free square scan: one cell a clock when not stalled, row-above sizes in a ram
// Cells of a binary grid arrive in raster order, one word per cell, and each gives one
// result word: the side of the largest free square with its bottom-right corner on that
// cell, plus the best side so far in the frame and its position; tlast marks the last
// cell. The block takes one cell every clock while m_tready is high: the row store is
// read ahead at the next scan position and written at the current one, and a single
// output register holds the result, so throughput is one cell per cycle while m_tready
// is high. column_count and row_count must be written only while the block is idle;
// the block itself does not enforce this. A value of 0 counts as 1.
module largest_free_square_scan_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] cell_free, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // square_size, best_size, best_row, best_col, then zeros
  output logic        m_tlast,   // frame_done
  input  logic        cfg_we,
  input  logic [lfss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfss_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [lfss_pkg::COUNT_W-1:0] MAX_COLS_C =
    lfss_pkg::COUNT_W'(lfss_pkg::MAX_COLUMNS);
  localparam logic [lfss_pkg::COUNT_W-1:0] MAX_ROWS_C =
    lfss_pkg::COUNT_W'(lfss_pkg::MAX_ROWS);
  localparam logic [lfss_pkg::SIZE_W-1:0] SIZE_MAX_C = '1;

  logic [lfss_pkg::COUNT_W-1:0] column_count;
  logic [lfss_pkg::COUNT_W-1:0] row_count;
  logic [lfss_pkg::POS_W-1:0]   col_pos;
  logic [lfss_pkg::POS_W-1:0]   row_pos;
  lfss_pkg::size_t              left_size;
  lfss_pkg::size_t              diag_size;
  lfss_pkg::size_t              best_len;
  logic [lfss_pkg::POS_W-1:0]   best_r;
  logic [lfss_pkg::POS_W-1:0]   best_c;

  logic [lfss_pkg::COUNT_W-1:0] cols;
  logic [lfss_pkg::COUNT_W-1:0] rows;
  logic [lfss_pkg::COUNT_W-1:0] col_p1;
  logic [lfss_pkg::COUNT_W-1:0] row_p1;
  logic                         wrap;
  logic                         done;
  logic [lfss_pkg::POS_W-1:0]   col_pos_next;
  logic [lfss_pkg::POS_W-1:0]   row_pos_next;

  lfss_pkg::size_t              up_size;
  lfss_pkg::size_t              min_lu;
  lfss_pkg::size_t              min_all;
  lfss_pkg::size_t              size;
  logic                         better;
  lfss_pkg::size_t              best_len_upd;
  logic [lfss_pkg::POS_W-1:0]   best_r_upd;
  logic [lfss_pkg::POS_W-1:0]   best_c_upd;
  lfss_pkg::ram_req_t           ram_req;
  logic                         accept;

  assign accept   = s_tvalid && s_tready;
  // no word is taken while in reset
  assign s_tready = !rst && (!m_tvalid || m_tready);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= MAX_COLS_C;
      row_count    <= MAX_ROWS_C;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfss_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data;
        lfss_pkg::CFG_ROW_COUNT:    row_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (column_count == '0) begin
      cols = lfss_pkg::COUNT_W'(1);
    end else if (column_count > MAX_COLS_C) begin
      cols = MAX_COLS_C;
    end else begin
      cols = column_count;
    end
    if (row_count == '0) begin
      rows = lfss_pkg::COUNT_W'(1);
    end else if (row_count > MAX_ROWS_C) begin
      rows = MAX_ROWS_C;
    end else begin
      rows = row_count;
    end
  end

  // scan position
  always_comb begin
    col_p1       = lfss_pkg::COUNT_W'(col_pos) + lfss_pkg::COUNT_W'(1);
    row_p1       = lfss_pkg::COUNT_W'(row_pos) + lfss_pkg::COUNT_W'(1);
    wrap         = col_p1 >= cols;
    done         = wrap && (row_p1 >= rows);
    col_pos_next = wrap ? '0 : col_p1[lfss_pkg::POS_W-1:0];
    if (!wrap) begin
      row_pos_next = row_pos;
    end else if (done) begin
      row_pos_next = '0;
    end else begin
      row_pos_next = row_p1[lfss_pkg::POS_W-1:0];
    end
  end

  // cell size
  always_comb begin
    min_lu  = (left_size < up_size) ? left_size : up_size;
    min_all = (min_lu < diag_size) ? min_lu : diag_size;
    if (!s_tdata[0]) begin
      size = '0;
    end else if ((row_pos == '0) || (col_pos == '0)) begin
      size = lfss_pkg::SIZE_W'(1);
    end else if (min_all == SIZE_MAX_C) begin
      size = SIZE_MAX_C;
    end else begin
      size = min_all + lfss_pkg::SIZE_W'(1);
    end
    better       = size > best_len;
    best_len_upd = better ? size : best_len;
    best_r_upd   = better ? row_pos : best_r;
    best_c_upd   = better ? col_pos : best_c;
  end

  // row store is read ahead at the position of the next cell
  always_comb begin
    ram_req.we      = accept;
    ram_req.wr_addr = lfss_pkg::COL_AW'(col_pos);
    ram_req.wr_data = size;
    ram_req.rd_addr = accept ? lfss_pkg::COL_AW'(col_pos_next) : lfss_pkg::COL_AW'(col_pos);
  end

  lfss_row_ram u_row_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (up_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      left_size <= '0;
      diag_size <= '0;
      best_len  <= '0;
      best_r    <= '0;
      best_c    <= '0;
    end else if (accept) begin
      col_pos   <= col_pos_next;
      row_pos   <= row_pos_next;
      left_size <= size;
      diag_size <= up_size;
      if (done) begin
        best_len <= '0;
        best_r   <= '0;
        best_c   <= '0;
      end else begin
        best_len <= best_len_upd;
        best_r   <= best_r_upd;
        best_c   <= best_c_upd;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'b0, best_c_upd, best_r_upd, best_len_upd, size};
      m_tlast <= done;
    end
  end

  a_accept_fills_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted cell produced no output word");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> (row_pos == '0) && (col_pos == '0) && (best_len == '0))
    else $error("frame end did not restart scan and best");

  a_best_covers_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:11] >= m_tdata[10:0]))
    else $error("best size below current square size");

  a_row_store_bypass: assert property (@(posedge clk) disable iff (rst)
    accept && (col_pos_next == col_pos) |=> up_size == $past(size))
    else $error("row store read missed same-column write");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the largest free square scan top level
`timescale 1ns / 1ps

module testbench;
  import lfss_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving anywhere
  localparam int RANDOM_CELLS = 400;
  localparam int HOLD_AT_RESULT = 100;  // falls inside the random part
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    size_t            square_size;
    size_t            best_size;
    logic [POS_W-1:0] best_row;
    logic [POS_W-1:0] best_col;
    logic             frame_done;
  } scan_result_t;

  typedef enum logic {ROW_CELL, ROW_CFG} step_kind_e;

  typedef struct {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   free;
    logic                   typed;
    scan_result_t           want;
  } step_row_t;

  localparam scan_result_t NO_RESULT = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [0] cell_free, rest zero
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [47:0]           m_tdata;        // square_size, best_size, best_row, best_col, zeros
  logic                  m_tlast;        // frame_done
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  largest_free_square_scan_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scan state mirrored in the bench
  logic [CFG_DATA_W-1:0] col_cnt = 11'd1024;
  logic [CFG_DATA_W-1:0] row_cnt = 11'd1024;
  size_t                 above_sizes [MAX_COLUMNS] = '{default: '0};
  size_t                 left_sz = '0;
  size_t                 diag_sz = '0;
  logic [POS_W-1:0]      col_at = '0;
  logic [POS_W-1:0]      row_at = '0;
  size_t                 best_sz = '0;
  logic [POS_W-1:0]      best_r = '0;
  logic [POS_W-1:0]      best_c = '0;

  scan_result_t pending_results [$];
  int           fail_cnt = 0;
  int           results_seen = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  int           idle_cycles = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic         frame_over = 1'b0;

  function automatic int eff_count(input logic [CFG_DATA_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // advance the scan by one cell and give the word it should produce
  function automatic scan_result_t scan_cell(input logic free);
    scan_result_t r;
    int           ncols;
    int           nrows;
    size_t        up;
    size_t        sz;
    size_t        m;
    ncols = eff_count(col_cnt, MAX_COLUMNS);
    nrows = eff_count(row_cnt, MAX_ROWS);
    up = above_sizes[col_at];
    sz = '0;
    if (free) begin
      if (row_at == 0 || col_at == 0) begin
        sz = 11'd1;
      end else begin
        m = (left_sz < up) ? left_sz : up;
        m = (m < diag_sz) ? m : diag_sz;
        sz = (m == '1) ? m : m + 11'd1;
      end
      // ties keep the earlier corner
      if (sz > best_sz) begin
        best_sz = sz;
        best_r = row_at;
        best_c = col_at;
      end
    end
    diag_sz = up;
    left_sz = sz;
    above_sizes[col_at] = sz;
    r.frame_done = 1'b0;
    if (int'(col_at) + 1 >= ncols) begin
      col_at = '0;
      if (int'(row_at) + 1 >= nrows) r.frame_done = 1'b1;
      else row_at = row_at + 1'b1;
    end else begin
      col_at = col_at + 1'b1;
    end
    r.square_size = sz;
    r.best_size = best_sz;
    r.best_row = best_r;
    r.best_col = best_c;
    if (r.frame_done) begin
      row_at = '0;
      best_sz = '0;
      best_r = '0;
      best_c = '0;
    end
    return r;
  endfunction

  task automatic feed_cell(input logic free, input logic typed, input scan_result_t want);
    scan_result_t r;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, free};
    do @(posedge clk); while (!s_tready);
    r = scan_cell(free);
    pending_results.push_back(typed ? want : r);
    frame_over = r.frame_done;
  endtask

  // registers only change once every word has come out
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLUMN_COUNT) col_cnt = val;
    else row_cnt = val;
  endtask

  step_row_t dir_tab [26] = '{
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b0, 1'b1, '{11'd0, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
    // column count drops below the current position
    '{ROW_CFG,  CFG_COLUMN_COUNT, 11'd2, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    // row count of zero, already past the last row
    '{ROW_CFG,  CFG_ROW_COUNT,    11'd0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_COLUMN_COUNT, 11'd0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_ROW_COUNT,    11'd3, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b0, 1'b1, '{11'd0, 11'd1, 10'd0, 10'd0, 1'b0}},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b1, '{11'd1, 11'd1, 10'd0, 10'd0, 1'b1}},
    // all blocked frame, best cleared after the frame end
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b0, 1'b1, '{11'd0, 11'd0, 10'd0, 10'd0, 1'b0}},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b0, 1'b1, '{11'd0, 11'd0, 10'd0, 10'd0, 1'b0}},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b0, 1'b1, '{11'd0, 11'd0, 10'd0, 10'd0, 1'b1}},
    '{ROW_CFG,  CFG_COLUMN_COUNT, 11'd3, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_ROW_COUNT,    11'd2, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CELL, CFG_COLUMN_COUNT, 11'd0, 1'b1, 1'b0, NO_RESULT}
  };

  initial begin
    int rnd_cells;
    int frame_no;
    int free_pct;
    int mid_at;
    int in_frame;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      else feed_cell(dir_tab[i].free, dir_tab[i].typed, dir_tab[i].want);
    end

    // counts above the maximum: a long first row, then fewer columns and rows end the frame
    write_reg(CFG_COLUMN_COUNT, 11'd2047);
    write_reg(CFG_ROW_COUNT, 11'd2047);
    for (int i = 0; i < 12; i++)
      feed_cell(1'b1, 1'b0, NO_RESULT);
    write_reg(CFG_COLUMN_COUNT, 11'd4);
    write_reg(CFG_ROW_COUNT, 11'd3);
    frame_over = 1'b0;
    while (!frame_over)
      feed_cell(1'b1, 1'b0, NO_RESULT);

    rnd_cells = 0;
    frame_no = 0;
    while (rnd_cells < RANDOM_CELLS) begin
      case (frame_no % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 61; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      write_reg(CFG_COLUMN_COUNT,
                ($urandom_range(7) == 0) ? 11'd0 : 11'($urandom_range(12, 1)));
      write_reg(CFG_ROW_COUNT,
                ($urandom_range(7) == 0) ? 11'd0 : 11'($urandom_range(10, 1)));
      free_pct = $urandom_range(98, 50);
      mid_at = ($urandom_range(3) == 0) ? $urandom_range(30, 1) : -1;
      in_frame = 0;
      frame_over = 1'b0;
      while (!frame_over) begin
        // mid-frame change: at most as many columns, or a row count from 0 to 10
        if (in_frame == mid_at) begin
          if ($urandom_range(1) == 0)
            write_reg(CFG_COLUMN_COUNT,
                      11'($urandom_range(eff_count(col_cnt, MAX_COLUMNS), 1)));
          else
            write_reg(CFG_ROW_COUNT, 11'($urandom_range(10, 0)));
        end
        feed_cell($urandom_range(99) < free_pct, 1'b0, NO_RESULT);
        in_frame++;
        rnd_cells++;
      end
      frame_no++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // output side: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // word layout: square_size [10:0], best_size [21:11], best_row [31:22], best_col [41:32]
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[10:0] !== want.square_size) begin
          $error("square_size: expected %0d, got %0d", want.square_size, m_tdata[10:0]);
          fail_cnt++;
        end
        if (m_tdata[21:11] !== want.best_size) begin
          $error("best_size: expected %0d, got %0d", want.best_size, m_tdata[21:11]);
          fail_cnt++;
        end
        if (m_tdata[31:22] !== want.best_row) begin
          $error("best_row: expected %0d, got %0d", want.best_row, m_tdata[31:22]);
          fail_cnt++;
        end
        if (m_tdata[41:32] !== want.best_col) begin
          $error("best_col: expected %0d, got %0d", want.best_col, m_tdata[41:32]);
          fail_cnt++;
        end
        if (m_tlast !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
